@@ rtl/matrix3x3_inverse_defines.svh @@
// ----------------------------------------------------------------------------
// matrix3x3_inverse assertion macros
// Shared property shapes for the 3x3 inverse block, clocked on clk and
// switched off while rst is high.
// ----------------------------------------------------------------------------
`ifndef MATRIX3X3_INVERSE_DEFINES_SVH
`define MATRIX3X3_INVERSE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define MI3_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MI3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/mi3_pkg.sv @@
// ----------------------------------------------------------------------------
// mi3_pkg
// Widths, result types and the rounding/clipping function shared by the
// 3x3 inverse datapath.
// ----------------------------------------------------------------------------
package mi3_pkg;

  // element and intermediate widths
  localparam int ELEM_W   = 32;
  localparam int N_ELEM   = 9;
  localparam int PROD_W   = 2 * ELEM_W;
  localparam int COF_W    = PROD_W + 1;
  localparam int LO_W     = ELEM_W;
  localparam int HI_W     = COF_W - LO_W;
  localparam int PART_W   = ELEM_W + HI_W;
  localparam int TERM_W   = ELEM_W + COF_W;
  localparam int DET_W    = TERM_W + 2;
  localparam int DMAG_W   = TERM_W;
  localparam int SCALE_SH = 32;
  localparam int NUM_W    = DMAG_W + 1;
  localparam int D2_W     = DMAG_W + 1;
  localparam int QUO_W    = ELEM_W + 2;
  localparam int CMP_W    = D2_W + QUO_W;
  localparam int RND_W    = DMAG_W + 1;

  // stream widths
  localparam int IN_W   = N_ELEM * ELEM_W;
  localparam int OUT_W  = (N_ELEM + 1) * ELEM_W;
  localparam int USER_W = 2;

  localparam logic [ELEM_W-1:0] MAX_POS = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic [ELEM_W-1:0] MIN_NEG = {1'b1, {(ELEM_W-1){1'b0}}};

  typedef struct packed {
    logic              sat;
    logic [ELEM_W-1:0] value;
  } res_t;

  typedef struct packed {
    logic              neg;
    logic [DMAG_W-1:0] mag;
  } det_info_t;

  typedef struct packed {
    logic zero;
    res_t res;
  } det_out_t;

  // rounded magnitude plus sign to a clipped Q16.16 code; top bit of q is
  // the "far too big" flag
  function automatic res_t sat_q(input logic [QUO_W-1:0] q, input logic neg);
    res_t r;
    r.sat   = 1'b0;
    r.value = q[ELEM_W-1:0];
    if (!neg) begin
      if (q[QUO_W-1:ELEM_W-1] != '0) begin
        r.sat   = 1'b1;
        r.value = MAX_POS;
      end
    end else begin
      if ((q[QUO_W-1:ELEM_W] != '0) || (q[ELEM_W-1] && (q[ELEM_W-2:0] != '0))) begin
        r.sat   = 1'b1;
        r.value = MIN_NEG;
      end else begin
        r.value = ELEM_W'(0) - q[ELEM_W-1:0];
      end
    end
    return r;
  endfunction

endpackage

@@ rtl/mi3_cofactor.sv @@
// ----------------------------------------------------------------------------
// mi3_cofactor
// One adjugate entry p*q - r*s at full width, two pipeline stages.
// ----------------------------------------------------------------------------
module mi3_cofactor (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [mi3_pkg::ELEM_W-1:0]   p,
  input  logic signed [mi3_pkg::ELEM_W-1:0]   q,
  input  logic signed [mi3_pkg::ELEM_W-1:0]   r,
  input  logic signed [mi3_pkg::ELEM_W-1:0]   s,
  output logic signed [mi3_pkg::COF_W-1:0]    adj
);

  logic signed [mi3_pkg::PROD_W-1:0] pq;
  logic signed [mi3_pkg::PROD_W-1:0] rs;

  // products, then their difference
  always_ff @(posedge clk) begin
    if (en) begin
      pq  <= p * q;
      rs  <= r * s;
      adj <= {pq[mi3_pkg::PROD_W-1], pq} - {rs[mi3_pkg::PROD_W-1], rs};
    end
  end

endmodule

@@ rtl/mi3_det.sv @@
// ----------------------------------------------------------------------------
// mi3_det
// Determinant by first-row expansion, its magnitude for the divider lanes
// and its own rounded, clipped Q16.16 value.
// ----------------------------------------------------------------------------
module mi3_det (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [mi3_pkg::ELEM_W-1:0]  a0,
  input  logic signed [mi3_pkg::ELEM_W-1:0]  a1,
  input  logic signed [mi3_pkg::ELEM_W-1:0]  a2,
  input  logic signed [mi3_pkg::COF_W-1:0]   c0,
  input  logic signed [mi3_pkg::COF_W-1:0]   c1,
  input  logic signed [mi3_pkg::COF_W-1:0]   c2,
  output mi3_pkg::det_info_t                 info,
  output mi3_pkg::det_out_t                  det_out
);

  logic signed [mi3_pkg::ELEM_W-1:0] a [3];
  logic signed [mi3_pkg::COF_W-1:0]  c [3];
  logic signed [mi3_pkg::PART_W-1:0] ph [3];
  logic signed [mi3_pkg::PART_W-1:0] pl [3];
  logic signed [mi3_pkg::TERM_W-1:0] term [3];
  logic signed [mi3_pkg::DET_W-1:0]  det;
  logic        [mi3_pkg::DET_W-1:0]  det_abs;
  logic                              det_zero;
  logic        [mi3_pkg::RND_W-1:0]  rsum;
  logic        [mi3_pkg::QUO_W-1:0]  rq;

  assign a[0] = a0;
  assign a[1] = a1;
  assign a[2] = a2;
  assign c[0] = c0;
  assign c[1] = c1;
  assign c[2] = c2;

  // split each wide cofactor into a signed high and unsigned low half
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        ph[k]   <= a[k] * $signed(c[k][mi3_pkg::COF_W-1:mi3_pkg::LO_W]);
        pl[k]   <= a[k] * $signed({1'b0, c[k][mi3_pkg::LO_W-1:0]});
        term[k] <= (mi3_pkg::TERM_W'(ph[k]) <<< mi3_pkg::LO_W) + mi3_pkg::TERM_W'(pl[k]);
      end
    end
  end

  // sum of the three terms
  always_ff @(posedge clk) begin
    if (en) begin
      det <= mi3_pkg::DET_W'(term[0]) + mi3_pkg::DET_W'(term[1]) + mi3_pkg::DET_W'(term[2]);
    end
  end

  // sign, magnitude and zero test
  assign det_abs = det[mi3_pkg::DET_W-1] ? (~det + 1'b1) : det;

  always_ff @(posedge clk) begin
    if (en) begin
      info.neg <= det[mi3_pkg::DET_W-1];
      info.mag <= det_abs[mi3_pkg::DMAG_W-1:0];
      det_zero <= (det == '0);
    end
  end

  // det / 2^32 rounded half away from zero
  assign rsum = {1'b0, info.mag} + (mi3_pkg::RND_W'(1) << (mi3_pkg::SCALE_SH - 1));
  assign rq   = {|rsum[mi3_pkg::RND_W-1:mi3_pkg::SCALE_SH+mi3_pkg::QUO_W-1],
                 rsum[mi3_pkg::SCALE_SH+mi3_pkg::QUO_W-2:mi3_pkg::SCALE_SH]};

  always_ff @(posedge clk) begin
    if (en) begin
      det_out.zero <= det_zero;
      det_out.res  <= mi3_pkg::sat_q(rq, info.neg);
    end
  end

endmodule

@@ rtl/mi3_div_lane.sv @@
// ----------------------------------------------------------------------------
// mi3_div_lane
// One inverse element: round(adj * 2^32 / det) as a sign and a 34-bit
// quotient, by a fully pipelined restoring divider, one bit per stage.
// ----------------------------------------------------------------------------
module mi3_div_lane (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [mi3_pkg::COF_W-1:0]  adj,
  input  logic        [mi3_pkg::DMAG_W-1:0] dmag,
  input  logic                              dneg,
  output logic        [mi3_pkg::QUO_W-1:0]  q,
  output logic                              neg
);

  localparam int NS = mi3_pkg::QUO_W;

  logic [mi3_pkg::COF_W-1:0] amag;
  logic [mi3_pkg::NUM_W-1:0] rem [NS+1];
  logic [mi3_pkg::D2_W-1:0]  dv  [NS+1];
  logic [mi3_pkg::QUO_W-1:0] qb  [NS+1];
  logic                      ng  [NS+1];

  assign amag = adj[mi3_pkg::COF_W-1] ? (~adj + 1'b1) : adj;

  // numerator 2*|adj|*2^32 + |det|, divisor 2*|det|
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= mi3_pkg::NUM_W'({amag, {(mi3_pkg::SCALE_SH+1){1'b0}}})
              + mi3_pkg::NUM_W'(dmag);
      dv[0]  <= {dmag, 1'b0};
      qb[0]  <= '0;
      ng[0]  <= adj[mi3_pkg::COF_W-1] ^ dneg;
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam int B = NS - 1 - s;
    logic [mi3_pkg::CMP_W-1:0] shd;
    logic [mi3_pkg::CMP_W-1:0] rx;
    logic                      take;

    assign shd  = mi3_pkg::CMP_W'(dv[s]) << B;
    assign rx   = mi3_pkg::CMP_W'(rem[s]);
    assign take = (rx >= shd);

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= take ? mi3_pkg::NUM_W'(rx - shd) : rem[s];
        dv[s+1]  <= dv[s];
        qb[s+1]  <= qb[s] | (mi3_pkg::QUO_W'(take) << B);
        ng[s+1]  <= ng[s];
      end
    end
  end

  assign q   = qb[NS];
  assign neg = ng[NS];

endmodule

@@ rtl/mi3_merge.sv @@
// ----------------------------------------------------------------------------
// mi3_merge
// Clips the nine lane quotients, applies the singular case and gathers the
// clip flags into one result item; this is the output register.
// ----------------------------------------------------------------------------
module mi3_merge (
  input  logic                                              clk,
  input  logic                                              en,
  input  logic [mi3_pkg::N_ELEM-1:0][mi3_pkg::QUO_W-1:0]    q,
  input  logic [mi3_pkg::N_ELEM-1:0]                        neg,
  input  mi3_pkg::det_out_t                                 det,
  output logic [mi3_pkg::N_ELEM-1:0][mi3_pkg::ELEM_W-1:0]   inv,
  output logic [mi3_pkg::ELEM_W-1:0]                        det_value,
  output logic                                              singular,
  output logic                                              saturated
);

  mi3_pkg::res_t lane_res [mi3_pkg::N_ELEM];
  logic          sat_any;

  // per-lane clipping and flag merge
  always_comb begin
    sat_any = det.res.sat;
    for (int k = 0; k < mi3_pkg::N_ELEM; k++) begin
      lane_res[k] = mi3_pkg::sat_q(q[k], neg[k]);
      sat_any     = sat_any | lane_res[k].sat;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < mi3_pkg::N_ELEM; k++) begin
        inv[k] <= det.zero ? '0 : lane_res[k].value;
      end
      det_value <= det.res.value;
      singular  <= det.zero;
      saturated <= det.zero ? 1'b0 : sat_any;
    end
  end

endmodule

@@ rtl/matrix3x3_inverse.sv @@
// An item passes the input register, cofactors, determinant, divider lanes and output register.
// Throughput: one item per cycle while the output side is ready.
// The depth is set by the 34-stage bit-per-stage divider in each of the
// nine inverse lanes; the whole pipeline holds while a result waits.
// Reset clears only the stage valid flags; data registers are not reset.
// ----------------------------------------------------------------------------
// matrix3x3_inverse
// Inverse and determinant of one signed Q16.16 3x3 matrix per item, via
// adjugate and exact division, rounded and clipped to Q16.16.
// ----------------------------------------------------------------------------
`include "matrix3x3_inverse_defines.svh"

module matrix3x3_inverse (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // m11 m12 m13 m21 m22 m23 m31 m32 m33, 32 bits each
  input  logic [mi3_pkg::IN_W-1:0]      s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // inv11 .. inv33 then det_value, 32 bits each
  output logic [mi3_pkg::OUT_W-1:0]     m_axis_tdata,
  // singular, saturated
  output logic [mi3_pkg::USER_W-1:0]    m_axis_tuser
);

  localparam int COF_LAT  = 2;
  localparam int INFO_LAT = 4;
  localparam int RES_LAT  = 5;
  localparam int LANE_LAT = mi3_pkg::QUO_W + 1;
  localparam int LAT      = 1 + COF_LAT + INFO_LAT + LANE_LAT + 1;
  localparam int A_DLY    = COF_LAT;
  localparam int ADJ_DLY  = INFO_LAT;
  localparam int DET_DLY  = INFO_LAT + LANE_LAT - RES_LAT;

  // cofactor operand indexes into the row-major element list
  localparam int COF_P [mi3_pkg::N_ELEM] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int COF_Q [mi3_pkg::N_ELEM] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int COF_R [mi3_pkg::N_ELEM] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int COF_S [mi3_pkg::N_ELEM] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  logic                                  en;
  logic [LAT-1:0]                        vld;
  logic signed [mi3_pkg::ELEM_W-1:0]     in_r    [mi3_pkg::N_ELEM];
  logic signed [mi3_pkg::ELEM_W-1:0]     a_dly   [A_DLY][3];
  logic signed [mi3_pkg::COF_W-1:0]      adj     [mi3_pkg::N_ELEM];
  logic signed [mi3_pkg::COF_W-1:0]      adj_dly [ADJ_DLY][mi3_pkg::N_ELEM];
  mi3_pkg::det_info_t                    info;
  mi3_pkg::det_out_t                     det_res;
  mi3_pkg::det_out_t                     det_dly [DET_DLY];
  logic [mi3_pkg::N_ELEM-1:0][mi3_pkg::QUO_W-1:0]  lane_q;
  logic [mi3_pkg::N_ELEM-1:0]                      lane_neg;
  logic [mi3_pkg::N_ELEM-1:0][mi3_pkg::ELEM_W-1:0] inv;
  logic [mi3_pkg::ELEM_W-1:0]            det_value;
  logic                                  singular;
  logic                                  saturated;

  // whole pipeline advances unless a result is held at the output
  assign en            = !vld[LAT-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_axis_tvalid};
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < mi3_pkg::N_ELEM; k++) begin
        in_r[k] <= s_axis_tdata[k*mi3_pkg::ELEM_W +: mi3_pkg::ELEM_W];
      end
    end
  end

  // first-row elements wait for their cofactors
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        a_dly[0][j] <= in_r[j];
      end
      for (int d = 1; d < A_DLY; d++) begin
        a_dly[d] <= a_dly[d-1];
      end
    end
  end

  // adjugate lanes
  for (genvar k = 0; k < mi3_pkg::N_ELEM; k++) begin : g_cof
    mi3_cofactor u_cof (
      .clk (clk),
      .en  (en),
      .p   (in_r[COF_P[k]]),
      .q   (in_r[COF_Q[k]]),
      .r   (in_r[COF_R[k]]),
      .s   (in_r[COF_S[k]]),
      .adj (adj[k])
    );
  end

  mi3_det u_det (
    .clk     (clk),
    .en      (en),
    .a0      (a_dly[A_DLY-1][0]),
    .a1      (a_dly[A_DLY-1][1]),
    .a2      (a_dly[A_DLY-1][2]),
    .c0      (adj[0]),
    .c1      (adj[3]),
    .c2      (adj[6]),
    .info    (info),
    .det_out (det_res)
  );

  // adjugate waits for the determinant magnitude
  always_ff @(posedge clk) begin
    if (en) begin
      adj_dly[0] <= adj;
      for (int d = 1; d < ADJ_DLY; d++) begin
        adj_dly[d] <= adj_dly[d-1];
      end
    end
  end

  // divider lanes
  for (genvar k = 0; k < mi3_pkg::N_ELEM; k++) begin : g_lane
    mi3_div_lane u_lane (
      .clk  (clk),
      .en   (en),
      .adj  (adj_dly[ADJ_DLY-1][k]),
      .dmag (info.mag),
      .dneg (info.neg),
      .q    (lane_q[k]),
      .neg  (lane_neg[k])
    );
  end

  // determinant result waits for the lanes
  always_ff @(posedge clk) begin
    if (en) begin
      det_dly[0] <= det_res;
      for (int d = 1; d < DET_DLY; d++) begin
        det_dly[d] <= det_dly[d-1];
      end
    end
  end

  mi3_merge u_merge (
    .clk       (clk),
    .en        (en),
    .q         (lane_q),
    .neg       (lane_neg),
    .det       (det_dly[DET_DLY-1]),
    .inv       (inv),
    .det_value (det_value),
    .singular  (singular),
    .saturated (saturated)
  );

  assign m_axis_tdata = {det_value, inv};
  assign m_axis_tuser = {saturated, singular};

  // checks
  `MI3_ASSERT_NOW(a_sing_zero_inv, m_axis_tvalid && singular,
    (inv == '0) && !saturated, "singular item with nonzero inverse or clip flag")
  `MI3_ASSERT_NOW(a_sing_zero_det, m_axis_tvalid && singular,
    det_value == '0, "singular item with nonzero determinant")
  `MI3_ASSERT_NEXT(a_accept_enters, s_axis_tvalid && s_axis_tready,
    vld[0], "accepted item missing from first stage")

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 3x3 matrix inverse. Matrices are streamed in
// under several source/sink throttling mixes; each accepted item is run
// through an exact wide-integer inverse predictor and the results are
// compared field by field, in order, against the output stream.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int ELEM_W = mi3_pkg::ELEM_W;
  localparam int IN_W   = mi3_pkg::IN_W;
  localparam int OUT_W  = mi3_pkg::OUT_W;
  localparam int USER_W = mi3_pkg::USER_W;
  localparam logic [ELEM_W-1:0] MAX_POS = mi3_pkg::MAX_POS;
  localparam logic [ELEM_W-1:0] MIN_NEG = mi3_pkg::MIN_NEG;

  typedef logic signed [255:0] big_t;

  typedef struct {
    logic [OUT_W-1:0]  data;
    logic [USER_W-1:0] user;
  } inv_result_t;

  localparam int USER_SINGULAR = 0;
  localparam int USER_SAT      = 1;
  localparam int LATENCY       = 42;
  localparam int STALL_LIMIT   = 20000;

  logic              clk;
  logic              rst;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [OUT_W-1:0]  m_axis_tdata;
  logic [USER_W-1:0] m_axis_tuser;

  inv_result_t pending_inverses[$];
  int          fail_count = 0;
  int          src_idle_pct;
  int          snk_stall_pct;
  int          idle_cycles;

  matrix3x3_inverse u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // n / d rounded half away from zero, clipped to signed 32 bits
  function automatic logic [ELEM_W-1:0] round_clip(input big_t n, input big_t d,
                                                   inout logic sat);
    logic neg;
    big_t an;
    big_t ad;
    big_t q;
    neg = (n < 0) != (d < 0);
    an  = (n < 0) ? -n : n;
    ad  = (d < 0) ? -d : d;
    q   = (2 * an + ad) / (2 * ad);
    if (!neg) begin
      if (q > 256'sh7FFFFFFF) begin
        sat = 1'b1;
        return MAX_POS;
      end
      return q[ELEM_W-1:0];
    end
    if (q > 256'sh80000000) begin
      sat = 1'b1;
      return MIN_NEG;
    end
    return ELEM_W'(0) - q[ELEM_W-1:0];
  endfunction

  // exact adjugate / determinant inverse of one packed matrix
  function automatic inv_result_t invert_matrix(input logic [IN_W-1:0] mat);
    big_t        a[9];
    big_t        adj[9];
    big_t        det;
    big_t        one_q32;
    logic signed [ELEM_W-1:0] e;
    logic        sat;
    inv_result_t r;
    for (int k = 0; k < 9; k++) begin
      e = mat[k*ELEM_W +: ELEM_W];
      a[k] = e;
    end
    adj[0] = a[4] * a[8] - a[5] * a[7];
    adj[1] = a[2] * a[7] - a[1] * a[8];
    adj[2] = a[1] * a[5] - a[2] * a[4];
    adj[3] = a[5] * a[6] - a[3] * a[8];
    adj[4] = a[0] * a[8] - a[2] * a[6];
    adj[5] = a[2] * a[3] - a[0] * a[5];
    adj[6] = a[3] * a[7] - a[4] * a[6];
    adj[7] = a[1] * a[6] - a[0] * a[7];
    adj[8] = a[0] * a[4] - a[1] * a[3];
    det = a[0] * adj[0] + a[1] * adj[3] + a[2] * adj[6];
    r.data = '0;
    r.user = '0;
    if (det == 0) begin
      r.user[USER_SINGULAR] = 1'b1;
      return r;
    end
    sat = 1'b0;
    for (int k = 0; k < 9; k++)
      r.data[k*ELEM_W +: ELEM_W] = round_clip(adj[k] <<< 32, det, sat);
    one_q32 = big_t'(1) <<< 32;
    r.data[9*ELEM_W +: ELEM_W] = round_clip(det, one_q32, sat);
    r.user[USER_SAT] = sat;
    return r;
  endfunction

  // send one matrix item, with a random idle gap per the current mix
  task automatic send_matrix(input logic [IN_W-1:0] mat);
    logic taken;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= mat;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = s_axis_tready;
    end
    pending_inverses.push_back(invert_matrix(mat));
    @(negedge clk);
  endtask

  // drop valid and wait for the pipeline to drain
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (pending_inverses.size() != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  function automatic logic [ELEM_W-1:0] q16(input int v);
    return ELEM_W'(v) << 16;
  endfunction

  function automatic logic [IN_W-1:0] pack9(input logic [ELEM_W-1:0] e[9]);
    logic [IN_W-1:0] m;
    for (int k = 0; k < 9; k++) m[k*ELEM_W +: ELEM_W] = e[k];
    return m;
  endfunction

  // one element: full range, small fractional, or small integer
  function automatic logic [ELEM_W-1:0] rand_elem(input int kind);
    case (kind)
      0: begin
        return $urandom;
      end
      1: begin
        return ELEM_W'($signed($urandom_range(1 << 20)) - (1 << 19));
      end
      default: begin
        return q16($signed($urandom_range(16)) - 8);
      end
    endcase
  endfunction

  task automatic test_directed;
    logic [ELEM_W-1:0] e[9];
    // identity
    e = '{q16(1), 0, 0, 0, q16(1), 0, 0, 0, q16(1)};
    send_matrix(pack9(e));
    // zero matrix, singular
    e = '{default: 0};
    send_matrix(pack9(e));
    // all max positive, singular
    e = '{default: MAX_POS};
    send_matrix(pack9(e));
    // all min negative, singular
    e = '{default: MIN_NEG};
    send_matrix(pack9(e));
    // diagonal extremes, det saturates high and low
    e = '{MAX_POS, 0, 0, 0, MAX_POS, 0, 0, 0, MAX_POS};
    send_matrix(pack9(e));
    e = '{MIN_NEG, 0, 0, 0, MIN_NEG, 0, 0, 0, MIN_NEG};
    send_matrix(pack9(e));
    e = '{MIN_NEG, 0, 0, 0, MAX_POS, 0, 0, 0, MAX_POS};
    send_matrix(pack9(e));
    // tiny nonzero determinant: inverse clips
    e = '{32'd1, 0, 0, 0, 32'd1, 0, 0, 0, 32'd1};
    send_matrix(pack9(e));
    e = '{32'hFFFF_FFFF, 0, 0, 0, 32'd1, 0, 0, 0, 32'd1};
    send_matrix(pack9(e));
    // exact halves: diag(2,2,2) and diag(-2,...) invert to exactly 1/2 and -1/2
    e = '{q16(2), 0, 0, 0, q16(2), 0, 0, 0, q16(2)};
    send_matrix(pack9(e));
    e = '{q16(-2), 0, 0, 0, q16(-2), 0, 0, 0, q16(-2)};
    send_matrix(pack9(e));
    // inverse of 1/3 scale lands between codes
    e = '{q16(3), 0, 0, 0, q16(-3), 0, 0, 0, q16(3)};
    send_matrix(pack9(e));
    // inverse value exactly at -2^31 boundary: diag(1/2^15) style
    e = '{32'd2, 0, 0, 0, 32'd2, 0, 0, 0, 32'hFFFF_FFFE};
    send_matrix(pack9(e));
    // general full matrix
    e = '{q16(2), q16(-1), 0, q16(-1), q16(2), q16(-1), 0, q16(-1), q16(2)};
    send_matrix(pack9(e));
    // dependent rows, singular
    e = '{q16(1), q16(2), q16(3), q16(2), q16(4), q16(6), q16(7), q16(8), q16(9)};
    send_matrix(pack9(e));
    // permutation with sign
    e = '{0, q16(-1), 0, q16(1), 0, 0, 0, 0, q16(1)};
    send_matrix(pack9(e));
    // mixed extremes off the diagonal
    e = '{MAX_POS, MIN_NEG, MAX_POS, MIN_NEG, MAX_POS, 32'd1, 32'd1, MIN_NEG, MAX_POS};
    send_matrix(pack9(e));
    drain();
  endtask

  // random matrices; some made singular by copying a row or column or clearing a row
  task automatic test_random(input int count, input int idle_pct, input int stall_pct);
    logic [ELEM_W-1:0] e[9];
    int kind;
    int r;
    src_idle_pct  = idle_pct;
    snk_stall_pct = stall_pct;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(2);
      for (int k = 0; k < 9; k++) e[k] = rand_elem(($urandom_range(9) == 0) ? 0 : kind);
      r = $urandom_range(9);
      if (r == 0) begin
        for (int c = 0; c < 3; c++) e[6 + c] = e[c];
      end else if (r == 1) begin
        for (int c = 0; c < 3; c++) e[3 + c] = 0;
      end else if (r == 2) begin
        for (int c = 0; c < 3; c++) e[3*c + 2] = e[3*c + 1];
      end
      send_matrix(pack9(e));
    end
    drain();
  endtask

  // sink backpressure
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    inv_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_inverses.size() == 0) begin
        $display("%0t: unexpected result data=%h user=%b", $realtime,
                 m_axis_tdata, m_axis_tuser);
        fail_count++;
      end else begin
        want = pending_inverses.pop_front();
        for (int k = 0; k < 10; k++) begin
          if (m_axis_tdata[k*ELEM_W +: ELEM_W] !== want.data[k*ELEM_W +: ELEM_W]) begin
            $display("%0t: field %0d expected %h actual %h", $realtime, k,
                     want.data[k*ELEM_W +: ELEM_W], m_axis_tdata[k*ELEM_W +: ELEM_W]);
            fail_count++;
          end
        end
        if (m_axis_tuser[USER_SINGULAR] !== want.user[USER_SINGULAR]) begin
          $display("%0t: singular expected %b actual %b", $realtime,
                   want.user[USER_SINGULAR], m_axis_tuser[USER_SINGULAR]);
          fail_count++;
        end
        if (m_axis_tuser[USER_SAT] !== want.user[USER_SAT]) begin
          $display("%0t: saturated expected %b actual %b", $realtime,
                   want.user[USER_SAT], m_axis_tuser[USER_SAT]);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_random(400, 0, 0);
    test_random(400, 61, 0);
    test_random(400, 0, 61);
    test_random(400, 10, 10);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
